// ===== rtl/core/poly_eval_pkg.sv =====
// Shared constants, types and saturating arithmetic helpers for the polynomial evaluator.
// Used by polynomial_evaluator_unit. This package depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package poly_eval_pkg;

  // Q16.16 fixed-point format. The logic below stays correct for any value from 0 to 31.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned NUM_COEFFS = 8;
  localparam int unsigned NUM_STEPS  = NUM_COEFFS - 1;
  localparam int unsigned COEF_IDX_W = $clog2(NUM_COEFFS);
  localparam int unsigned ADDR_W     = COEF_IDX_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // A saturated value together with the flag that records a clip.
  typedef struct packed {
    logic  ovf;
    data_t val;
  } sat_t;

  // Arithmetic right shift (floor) of a full product, then clip to the data range.
  function automatic sat_t shift_sat(input prod_t p);
    prod_t                 shifted;
    logic [PROD_W-DATA_W:0] top;
    sat_t                  res;
    shifted = p >>> FRAC_BITS;
    top     = shifted[PROD_W-1:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      res.ovf = 1'b0;
      res.val = shifted[DATA_W-1:0];
    end else begin
      res.ovf = 1'b1;
      res.val = shifted[PROD_W-1] ? DATA_MIN : DATA_MAX;
    end
    return res;
  endfunction

  // Signed add with clipping to the data range.
  function automatic sat_t add_sat(input data_t a, input data_t b);
    logic [DATA_W:0] sum;
    sat_t            res;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      res.ovf = 1'b1;
      res.val = sum[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      res.ovf = 1'b0;
      res.val = sum[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/polynomial_evaluator_unit.sv =====
// Pipelined Horner-rule polynomial evaluator (degree up to seven, signed Q16.16).
// Throughput: one item per cycle unless a stalled result holds the pipe; each of the seven
// Horner steps is a multiply stage and a shift/saturate/add stage. Reset clears the
// coefficients to zero and empties the pipe.
// Depends on poly_eval_pkg.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_evaluator_unit
  import poly_eval_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,

  // Configuration port: coefficient i lies at byte address 4*i.
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [ADDR_W-1:0]  paddr,
  input  wire  [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,

  // Argument channel.
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [DATA_W-1:0]  arg_x_i,

  // Result channel.
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [DATA_W-1:0]  poly_value_o,
  output logic               overflow_o
);

  // ---------------------------------------------------------------------------
  // Coefficient registers. Software is to write them only while no item is in flight
  // (the block does not enforce this), so every stage can read its coefficient straight from here.
  // ---------------------------------------------------------------------------
  data_t                 coeff_q [NUM_COEFFS];
  logic [COEF_IDX_W-1:0] cfg_idx;
  logic                  cfg_wr;

  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = coeff_q[cfg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      coeff_q[cfg_idx] <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipe moves together unless the result register holds
  // an item that the consumer stalls. A one-item skid register in front of the
  // pipe keeps the input stall a pure register output, so the producer never sees
  // the consumer's stall combinationally.
  // ---------------------------------------------------------------------------
  logic  advance;
  logic  in_accept;
  logic  skid_valid_q;
  data_t skid_x_q;
  logic  src_valid;
  data_t src_x;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign src_valid  = skid_valid_q || in_valid_i;
  assign src_x      = skid_valid_q ? skid_x_q : arg_x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!advance && in_accept) begin
      skid_x_q <= arg_x_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Horner steps. Step k multiplies the running value by x in its first stage and
  // in its second stage floors the product by the fraction width, clips it, adds
  // the coefficient of x to the power (NUM_STEPS-1-k) and clips again. The running
  // value enters the first step as the top coefficient. The overflow flag travels
  // with the item and collects every clip.
  // ---------------------------------------------------------------------------
  data_t mul_acc_in [NUM_STEPS];
  data_t mul_x_in   [NUM_STEPS];
  logic  mul_v_in   [NUM_STEPS];
  logic  mul_ov_in  [NUM_STEPS];

  prod_t prod_q     [NUM_STEPS];
  data_t mx_q       [NUM_STEPS];
  logic  mv_q       [NUM_STEPS];
  logic  mov_q      [NUM_STEPS];

  data_t acc_q      [NUM_STEPS];
  data_t ax_q       [NUM_STEPS];
  logic  av_q       [NUM_STEPS];
  logic  aov_q      [NUM_STEPS];

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    localparam int unsigned CoefIdx = NUM_STEPS - 1 - k;

    sat_t  prod_sat;
    sat_t  sum_sat;
    prod_t prod_d;

    if (k == 0) begin : g_first
      assign mul_acc_in[k] = coeff_q[NUM_COEFFS-1];
      assign mul_x_in[k]   = src_x;
      assign mul_v_in[k]   = src_valid;
      assign mul_ov_in[k]  = 1'b0;
    end else begin : g_next
      assign mul_acc_in[k] = acc_q[k-1];
      assign mul_x_in[k]   = ax_q[k-1];
      assign mul_v_in[k]   = av_q[k-1];
      assign mul_ov_in[k]  = aov_q[k-1];
    end

    assign prod_d   = mul_acc_in[k] * mul_x_in[k];
    assign prod_sat = shift_sat(prod_q[k]);
    assign sum_sat  = add_sat(prod_sat.val, coeff_q[CoefIdx]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[k] <= 1'b0;
        av_q[k] <= 1'b0;
      end else if (advance) begin
        mv_q[k] <= mul_v_in[k];
        av_q[k] <= mv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        prod_q[k] <= prod_d;
        mx_q[k]   <= mul_x_in[k];
        mov_q[k]  <= mul_ov_in[k];
        acc_q[k]  <= sum_sat.val;
        ax_q[k]   <= mx_q[k];
        aov_q[k]  <= mov_q[k] | prod_sat.ovf | sum_sat.ovf;
      end
    end
  end

  // The last step's register is the result register.
  assign out_valid_o  = av_q[NUM_STEPS-1];
  assign poly_value_o = acc_q[NUM_STEPS-1];
  assign overflow_o   = aov_q[NUM_STEPS-1];
  assign advance      = !(out_valid_o && out_stall_i);

endmodule

`default_nettype wire

// ===== verif/polynomial_evaluator_unit_test.sv =====
// Self-checking testbench for the pipelined Horner polynomial evaluator.
// Drives coefficients over the APB port and arguments through the item channel, then checks
// each result against a fixed-point predictor. Depends on poly_eval_pkg and the unit.
`timescale 1ns / 1ps

module polynomial_evaluator_unit_test;
  import poly_eval_pkg::*;

  // Register indexes of the coefficient bank. Coefficient i is the factor of x to the i-th.
  localparam int REG_COEFF_0 = 0;
  localparam int REG_COEFF_1 = 1;
  localparam int REG_COEFF_2 = 2;
  localparam int REG_COEFF_3 = 3;
  localparam int REG_COEFF_4 = 4;
  localparam int REG_COEFF_5 = 5;
  localparam int REG_COEFF_6 = 6;
  localparam int REG_COEFF_7 = 7;

  // The drain pause is longer than the unit's path from acceptance to result, leaving some margin.
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_SETS  = 10;
  localparam int ITEMS_PER_SET = 105;

  // One Q16.16 value: 1.0 is 2^16.
  localparam data_t ONE = 32'sh0001_0000;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_e;

  // What the unit should produce for one argument.
  typedef struct {
    data_t value;
    logic  ovf;
  } poly_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] arg_x_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DATA_W-1:0] poly_value_o;
  logic              overflow_o;

  // Testbench copy of the coefficient bank, updated as each write completes.
  data_t        coeff_model [NUM_COEFFS];
  // Results predicted for accepted arguments, oldest first.
  poly_result_t pending_results [$];

  int          error_count = 0;
  int          cycle_count = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic        stall_hold = 1'b0;
  int          stall_phase = 0;
  logic        sender_gaps = 1'b0;
  int          burst_left = 0;

  polynomial_evaluator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .arg_x_i      (arg_x_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .poly_value_o (poly_value_o),
    .overflow_o   (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hang: a correct run ends far below this count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[polynomial_evaluator_unit] ERROR");
      $finish;
    end
  end

  // Clip a wide intermediate to the 32-bit signed range and note any clipping.
  function automatic longint clip_to_data(input longint v, inout logic ovf);
    if (v > longint'(DATA_MAX)) begin
      ovf = 1'b1;
      return longint'(DATA_MAX);
    end
    if (v < longint'(DATA_MIN)) begin
      ovf = 1'b1;
      return longint'(DATA_MIN);
    end
    return v;
  endfunction

  // Horner evaluation in the unit's fixed-point terms. The accumulator starts at the top
  // coefficient. Every step multiplies exactly, shifts right arithmetically (so the fraction
  // is dropped toward minus infinity), clips, adds the next coefficient and clips again.
  function automatic poly_result_t horner_eval(input data_t x);
    longint       acc;
    longint       prod;
    longint       xs;
    poly_result_t r;
    r.ovf = 1'b0;
    xs    = longint'(x);
    acc   = longint'(coeff_model[NUM_COEFFS-1]);
    for (int i = NUM_COEFFS - 2; i >= 0; i--) begin
      prod = (acc * xs) >>> FRAC_BITS;
      prod = clip_to_data(prod, r.ovf);
      acc  = clip_to_data(prod + longint'(coeff_model[i]), r.ovf);
    end
    r.value = data_t'(acc[DATA_W-1:0]);
    return r;
  endfunction

  // A uniform value in [-span, span] in raw Q16.16 units.
  function automatic data_t rand_fixed(input int unsigned span);
    return data_t'($urandom_range(0, 2 * span)) - data_t'(span);
  endfunction

  // Corner values of the Q16.16 range.
  function automatic data_t pick_special();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return DATA_MAX;
      2:       return DATA_MIN;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  // Arguments are mostly small so that the higher powers stay in range and the result
  // carries real information; the rest are full-range and corner values.
  function automatic data_t rand_arg();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return rand_fixed(4 * ONE);
    if (roll < 85) return data_t'($urandom);
    return pick_special();
  endfunction

  // The receiver: a long hold-off overrides the selected pattern.
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= stall_hold;
      end
      STALL_RANDOM: begin
        out_stall_i <= stall_hold || ($urandom_range(0, 99) < 40);
      end
      default: begin
        out_stall_i <= stall_hold || (stall_phase < 3);
      end
    endcase
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    poly_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h overflow=%b", $time, poly_value_o,
                 overflow_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (poly_value_o !== exp_res.value) begin
          $display("%0t: poly_value expected %h actual %h", $time, exp_res.value,
                   poly_value_o);
          error_count++;
        end
        if (overflow_o !== exp_res.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_res.ovf, overflow_o);
          error_count++;
        end
      end
    end
  end

  // Write one coefficient, then read it back. Called only while the pipe is empty.
  task automatic write_coeff(input int idx, input data_t val);
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'(4 * idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    coeff_model[idx] = val;
    // Read phase follows directly with psel still high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $display("%0t: coeff_%0d readback expected %h actual %h", $time, idx, val, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    // An idle gap keeps the bus released before the next transfer starts.
    @(posedge clk_i);
  endtask

  // Offer one argument and wait for its acceptance. Valid stays high afterwards so that
  // back-to-back items never lower and raise it in the same step.
  task automatic send_arg(input data_t x);
    in_valid_i <= 1'b1;
    arg_x_i    <= x;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(horner_eval(x));
  endtask

  // Sender pacing: bursts of random length separated by random gaps when enabled.
  task automatic offer_arg(input data_t x);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_arg(x);
  endtask

  // Drop valid and let every outstanding item come out, plus a pause longer than the pipeline depth.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Out of reset all coefficients are zero, so every argument gives zero.
  task automatic test_reset_defaults();
    stall_mode  = STALL_NONE;
    sender_gaps = 1'b0;
    offer_arg('0);
    offer_arg(DATA_MAX);
    offer_arg(DATA_MIN);
    wait_drained();
  endtask

  // p(x) = (1 LSB) * x: the product's fraction is dropped toward minus infinity,
  // so a tiny negative argument gives -1 LSB rather than zero.
  task automatic test_fraction_truncation();
    write_coeff(REG_COEFF_1, 32'sd1);
    offer_arg(-32'sd1);
    offer_arg(32'sd1);
    offer_arg(DATA_MIN);
    offer_arg(DATA_MAX);
    offer_arg(ONE);
    wait_drained();
  endtask

  // All coefficients 1.0: a full degree-seven sum, ending in saturation for larger x.
  task automatic test_unit_coefficients();
    for (int i = REG_COEFF_0; i <= REG_COEFF_7; i++) write_coeff(i, ONE);
    stall_mode = STALL_PERIODIC;
    offer_arg(ONE);
    offer_arg(-ONE);
    offer_arg(2 * ONE);
    offer_arg(8 * ONE);
    wait_drained();
  endtask

  // Extreme coefficients push both the shifted product and the sum past the range;
  // later steps carry on from the clipped value.
  task automatic test_saturation();
    write_coeff(REG_COEFF_7, DATA_MAX);
    for (int i = REG_COEFF_0; i < REG_COEFF_7; i++) write_coeff(i, DATA_MIN);
    stall_mode = STALL_RANDOM;
    offer_arg(DATA_MAX);
    offer_arg(DATA_MIN);
    offer_arg('0);
    offer_arg(32'sd1);
    wait_drained();
  endtask

  // Several random coefficient sets, from small ones that keep the sum in range up to
  // full-range and corner values, each followed by a stream of random arguments.
  task automatic test_random_settings();
    int unsigned style;
    for (int s = 0; s < RANDOM_SETS; s++) begin
      style = s % 4;
      for (int i = REG_COEFF_0; i <= REG_COEFF_7; i++) begin
        case (style)
          0:       write_coeff(i, rand_fixed(2 * ONE));
          1:       write_coeff(i, data_t'($urandom));
          2:       write_coeff(i, pick_special());
          default: write_coeff(i, ($urandom_range(0, 3) == 0) ? data_t'($urandom)
                                                              : rand_fixed(ONE / 2));
        endcase
      end
      stall_mode  = stall_mode_e'(s % 3);
      sender_gaps = (s % 4) != 3;
      for (int n = 0; n < ITEMS_PER_SET; n++) offer_arg(rand_arg());
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the pipe
  // fills and the unit has to stall its input.
  task automatic test_backpressure();
    for (int i = REG_COEFF_0; i <= REG_COEFF_7; i++) write_coeff(i, rand_fixed(ONE));
    stall_mode  = STALL_RANDOM;
    sender_gaps = 1'b0;
    fork
      begin
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_hold <= 1'b0;
      end
      begin
        for (int n = 0; n < 80; n++) offer_arg(rand_arg());
      end
    join
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_COEFFS; i++) coeff_model[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_fraction_truncation();
    test_unit_coefficients();
    test_saturation();
    test_random_settings();
    test_backpressure();

    if (error_count == 0) begin
      $display("[polynomial_evaluator_unit] OK");
    end else begin
      $display("[polynomial_evaluator_unit] ERROR");
    end
    $finish;
  end

endmodule
